// ----- rtl/core/uartrb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartrb_pkg
// Shared types and constants for the UART receive/transmit ring buffers.
// ----------------------------------------------------------------------------
package uartrb_pkg;

  localparam int BYTE_W      = 8;
  localparam int REQ_W       = 3;
  localparam int LEVEL_W     = 6;
  localparam int RX_DEPTH_DEF = 64;
  localparam int TX_DEPTH_DEF = 64;

  // Request codes carried in req_type
  typedef enum logic [REQ_W-1:0] {
    REQ_LINE_RX = 3'd0,
    REQ_TX_DONE = 3'd1,
    REQ_HOST_WR = 3'd2,
    REQ_WR_END  = 3'd3,
    REQ_HOST_RD = 3'd4
  } req_t;

  // Pointer moves for one ring in one cycle
  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctrl_t;

  // Ring occupancy status before the current beat
  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

  // Per-beat result flags
  typedef struct packed {
    logic line_valid;
    logic read_valid;
    logic write_accepted;
    logic rx_overwrote;
  } res_flags_t;

endpackage

// ----- rtl/core/uartrb_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartrb_req_if
// Request channel: valid/ready handshake with request code and data byte.
// ----------------------------------------------------------------------------
interface uartrb_req_if;
  logic                         valid;
  logic                         ready;
  logic [uartrb_pkg::REQ_W-1:0]  req_type;
  logic [uartrb_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

// ----- rtl/core/uartrb_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartrb_res_if
// Result channel: valid/ready handshake with flags, bytes and ring levels.
// ----------------------------------------------------------------------------
interface uartrb_res_if;
  logic                          valid;
  logic                          ready;
  logic                          line_valid;
  logic [uartrb_pkg::BYTE_W-1:0]  line_byte;
  logic                          read_valid;
  logic [uartrb_pkg::BYTE_W-1:0]  read_byte;
  logic                          write_accepted;
  logic                          rx_overwrote;
  logic [uartrb_pkg::LEVEL_W-1:0] rx_level;
  logic [uartrb_pkg::LEVEL_W-1:0] tx_level;

  modport source (output valid, output line_valid, output line_byte, output read_valid,
                  output read_byte, output write_accepted, output rx_overwrote,
                  output rx_level, output tx_level, input ready);
  modport sink   (input valid, input line_valid, input line_byte, input read_valid,
                  input read_byte, input write_accepted, input rx_overwrote,
                  input rx_level, input tx_level, output ready);
endinterface

// ----- rtl/core/uartrb_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartrb_ring
// One byte ring: write/read pointers, storage array and registered read port.
// ----------------------------------------------------------------------------
module uartrb_ring #(
  parameter int DEPTH = uartrb_pkg::RX_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  uartrb_pkg::ring_ctrl_t          ctrl,
  input  logic [uartrb_pkg::BYTE_W-1:0]    wdata,
  output uartrb_pkg::ring_stat_t          stat,
  output logic [uartrb_pkg::LEVEL_W-1:0]   level,
  output logic [uartrb_pkg::BYTE_W-1:0]    rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = (AW > uartrb_pkg::LEVEL_W) ? AW : uartrb_pkg::LEVEL_W;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(DEPTH);

  logic [uartrb_pkg::BYTE_W-1:0] store [DEPTH];
  logic [AW-1:0] wr_idx;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] wr_idx_next;
  logic [AW-1:0] rd_idx_next;
  logic [AW:0]   occ;
  logic [LW-1:0] occ_ext;

  // Wrapping increments
  assign wr_idx_next = (wr_idx == LAST) ? '0 : wr_idx + 1'b1;
  assign rd_idx_next = (rd_idx == LAST) ? '0 : rd_idx + 1'b1;

  assign stat.empty = (wr_idx == rd_idx);
  assign stat.full  = (wr_idx_next == rd_idx);

  // Occupancy, reported as its low bits
  always_comb begin
    if (wr_idx >= rd_idx) begin
      occ = {1'b0, wr_idx} - {1'b0, rd_idx};
    end else begin
      occ = {1'b0, wr_idx} + DEPTH_EXT - {1'b0, rd_idx};
    end
    occ_ext = LW'(occ[AW-1:0]);
  end

  assign level = occ_ext[uartrb_pkg::LEVEL_W-1:0];

  // Pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
    end else begin
      if (ctrl.push) wr_idx <= wr_idx_next;
      if (ctrl.pop)  rd_idx <= rd_idx_next;
    end
  end

  // Storage: write at the write pointer, registered read at the read pointer
  always_ff @(posedge clk) begin
    if (ctrl.push) store[wr_idx] <= wdata;
    if (ctrl.pop)  rdata <= store[rd_idx];
  end

endmodule

// ----- rtl/core/uartrb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartrb_ctrl
// Request decoder: turns one accepted beat into ring moves and result flags.
// ----------------------------------------------------------------------------
module uartrb_ctrl (
  input  logic                          fire,
  input  logic [uartrb_pkg::REQ_W-1:0]   req_type,
  input  uartrb_pkg::ring_stat_t        rx_stat,
  input  uartrb_pkg::ring_stat_t        tx_stat,
  output uartrb_pkg::ring_ctrl_t        rx_ctrl,
  output uartrb_pkg::ring_ctrl_t        tx_ctrl,
  output uartrb_pkg::res_flags_t        flags
);

  always_comb begin
    rx_ctrl = '0;
    tx_ctrl = '0;
    flags   = '0;
    unique case (uartrb_pkg::req_t'(req_type))
      // Line byte always lands; a full ring drops its oldest byte
      uartrb_pkg::REQ_LINE_RX: begin
        rx_ctrl.push       = 1'b1;
        rx_ctrl.pop        = rx_stat.full;
        flags.rx_overwrote = rx_stat.full;
      end
      // Transmit complete or end-of-write kick: send next queued byte
      uartrb_pkg::REQ_TX_DONE, uartrb_pkg::REQ_WR_END: begin
        tx_ctrl.pop      = !tx_stat.empty;
        flags.line_valid = !tx_stat.empty;
      end
      uartrb_pkg::REQ_HOST_WR: begin
        tx_ctrl.push         = !tx_stat.full;
        flags.write_accepted = !tx_stat.full;
      end
      uartrb_pkg::REQ_HOST_RD: begin
        rx_ctrl.pop      = !rx_stat.empty;
        flags.read_valid = !rx_stat.empty;
      end
      default: begin
      end
    endcase
    // Nothing moves without an accepted beat
    if (!fire) begin
      rx_ctrl = '0;
      tx_ctrl = '0;
    end
  end

endmodule

// ----- rtl/core/uart_rx_tx_ring_buffers.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers
// Receive and transmit byte rings for a serial port, one request per beat.
// ----------------------------------------------------------------------------
// Each request beat produces exactly one result beat in the cycle after it is
// taken. A new request is taken every cycle while the result side is ready;
// the result register holds a stalled result and request ready follows it.
// Each ring is an array with one write and one registered read per cycle,
// and holds at most depth minus one bytes. Levels report the low six bits.
module uart_rx_tx_ring_buffers #(
  parameter int RX_DEPTH = uartrb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = uartrb_pkg::TX_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  uartrb_req_if.sink   req,
  uartrb_res_if.source res
);

  uartrb_pkg::ring_ctrl_t rx_ctrl;
  uartrb_pkg::ring_ctrl_t tx_ctrl;
  uartrb_pkg::ring_stat_t rx_stat;
  uartrb_pkg::ring_stat_t tx_stat;
  uartrb_pkg::res_flags_t flags_d;
  uartrb_pkg::res_flags_t flags;
  logic [uartrb_pkg::BYTE_W-1:0] rx_rdata;
  logic [uartrb_pkg::BYTE_W-1:0] tx_rdata;
  logic out_valid;
  logic fire;

  assign req.ready = !out_valid || res.ready;
  assign fire      = req.valid && req.ready;

  uartrb_ctrl u_ctrl (
    .fire     (fire),
    .req_type (req.req_type),
    .rx_stat  (rx_stat),
    .tx_stat  (tx_stat),
    .rx_ctrl  (rx_ctrl),
    .tx_ctrl  (tx_ctrl),
    .flags    (flags_d)
  );

  uartrb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (rx_ctrl),
    .wdata (req.data_byte),
    .stat  (rx_stat),
    .level (res.rx_level),
    .rdata (rx_rdata)
  );

  uartrb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (tx_ctrl),
    .wdata (req.data_byte),
    .stat  (tx_stat),
    .level (res.tx_level),
    .rdata (tx_rdata)
  );

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req.ready) begin
      out_valid <= req.valid;
    end
  end

  // Result flags, held while the result stalls
  always_ff @(posedge clk) begin
    if (fire) flags <= flags_d;
  end

  // Result beat; bytes read as zero when their flag is low
  assign res.valid          = out_valid;
  assign res.line_valid     = flags.line_valid;
  assign res.line_byte      = flags.line_valid ? tx_rdata : '0;
  assign res.read_valid     = flags.read_valid;
  assign res.read_byte      = flags.read_valid ? rx_rdata : '0;
  assign res.write_accepted = flags.write_accepted;
  assign res.rx_overwrote   = flags.rx_overwrote;

endmodule

// ----- rtl/core/uartrb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartrb_checker
// Port-level checks for the ring buffer block, bound to the top level.
// ----------------------------------------------------------------------------
module uartrb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic                          line_valid,
  input logic [uartrb_pkg::BYTE_W-1:0]  line_byte,
  input logic                          read_valid,
  input logic [uartrb_pkg::BYTE_W-1:0]  read_byte,
  input logic                          write_accepted,
  input logic                          rx_overwrote
);

  // Every request beat yields a result beat in the next cycle
  a_res_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> res_valid)
    else $error("request beat without result beat");

  // A result beat reports at most one event
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot0({line_valid, read_valid, write_accepted, rx_overwrote}))
    else $error("more than one event flag in a result beat");

  // Bytes without their flag read as zero
  a_zero_bytes: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (line_valid || line_byte == '0) && (read_valid || read_byte == '0))
    else $error("byte not zero while its flag is low");

  // A stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(line_byte) && $stable(read_byte)
      && $stable(line_valid) && $stable(read_valid))
    else $error("stalled result beat changed");

endmodule

bind uart_rx_tx_ring_buffers uartrb_checker u_uartrb_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .line_valid     (res.line_valid),
  .line_byte      (res.line_byte),
  .read_valid     (res.read_valid),
  .read_byte      (res.read_byte),
  .write_accepted (res.write_accepted),
  .rx_overwrote   (res.rx_overwrote)
);
